FILE: src/q2r_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2r_pkg
// shared types and constants for the quaternion to rotation matrix core
// ----------------------------------------------------------------------------
package q2r_pkg;

	localparam int NumEnt   = 9;
	localparam int FracBits = 14;
	localparam int QuoBits  = FracBits + 2;
	localparam int MagBits  = 33;
	localparam int RemBits  = MagBits + 1;

	typedef struct packed {
		logic signed [15:0] quat_real;
		logic signed [15:0] quat_i;
		logic signed [15:0] quat_j;
		logic signed [15:0] quat_k;
	} quat_t;

	typedef struct packed {
		logic signed [15:0] m00;
		logic signed [15:0] m01;
		logic signed [15:0] m02;
		logic signed [15:0] m10;
		logic signed [15:0] m11;
		logic signed [15:0] m12;
		logic signed [15:0] m20;
		logic signed [15:0] m21;
		logic signed [15:0] m22;
		logic               too_small;
	} mat_t;

	// classified job handed from the front to the divider back end
	typedef struct packed {
		logic [NumEnt-1:0][MagBits-1:0] mag;
		logic [NumEnt-1:0]              neg;
		logic [MagBits-1:0]             norm;
		logic                           low_norm;
	} job_t;

endpackage
`default_nettype wire

FILE: src/quaternion_to_rotation_matrix_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_core
// converts one quaternion of any scale to a 3x3 rotation matrix in Q2.14
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  input   | in_valid, in_stall, in_data    | quaternion in
//  output  | out_valid, out_stall, out_data | nine entries plus too_small flag
//  config  | cfg_we, cfg_wdata              | small_norm_limit write
//
//  one transfer per cycle sustained on both channels while out_stall is low
//  path: 3 front stages, queue, 16 divider stages, output reg
//  the 16-stage nine-lane divider sets the depth, one quotient bit per stage
//  reset clears all valid bits and the limit register; no clearing pass
//  output stall freezes the back end; the two-entry queue lets the front run on
// ----------------------------------------------------------------------------
module quaternion_to_rotation_matrix_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire q2r_pkg::quat_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output q2r_pkg::mat_t      out_data
);
	import q2r_pkg::*;

	// front to queue
	logic push;
	job_t push_job;
	logic q_full;
	// queue to back
	logic pop;
	logic q_empty;
	job_t pop_job;

	// products, forms, magnitudes and limit check
	q2r_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	// decouples front stalls from output stalls
	q2r_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (q_full),
		.pop     (pop),
		.empty   (q_empty),
		.pop_job (pop_job)
	);

	// divider lanes, rounding to nearest, output register
	q2r_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.pop      (pop),
		.pop_job  (pop_job),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule
`default_nettype wire

FILE: src/q2r_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2r_front
// products, squared norm, quadratic forms and small-norm check
// ----------------------------------------------------------------------------
module q2r_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [31:0]   cfg_wdata,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire q2r_pkg::quat_t in_data,
	output logic               push,
	output q2r_pkg::job_t      push_job,
	input  wire logic          q_full
);
	import q2r_pkg::*;

	logic [31:0] limit_q;
	logic        en;
	logic        v_s1, v_s2, v_s3;

	logic signed [31:0] aa_s1, ab_s1, ac_s1, ad_s1, bb_s1, bc_s1, bd_s1, cc_s1, cd_s1, dd_s1;
	logic signed [RemBits-1:0] form_s2 [NumEnt];
	logic [MagBits-1:0]        norm_s2;
	job_t                      job_s3;

	logic signed [RemBits-1:0] aa, ab, ac, ad, bb, bc, bd, cc, cd, dd, nsum;

	assign en       = !v_s3 || !q_full;
	assign in_stall = !en;
	assign push     = v_s3 && !q_full;
	assign push_job = job_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1: ten pairwise products
	always_ff @(posedge clk) begin
		if (en) begin
			aa_s1 <= 32'(in_data.quat_real * in_data.quat_real);
			ab_s1 <= 32'(in_data.quat_real * in_data.quat_i);
			ac_s1 <= 32'(in_data.quat_real * in_data.quat_j);
			ad_s1 <= 32'(in_data.quat_real * in_data.quat_k);
			bb_s1 <= 32'(in_data.quat_i * in_data.quat_i);
			bc_s1 <= 32'(in_data.quat_i * in_data.quat_j);
			bd_s1 <= 32'(in_data.quat_i * in_data.quat_k);
			cc_s1 <= 32'(in_data.quat_j * in_data.quat_j);
			cd_s1 <= 32'(in_data.quat_j * in_data.quat_k);
			dd_s1 <= 32'(in_data.quat_k * in_data.quat_k);
		end
	end

	always_comb begin
		aa   = RemBits'(aa_s1);
		ab   = RemBits'(ab_s1);
		ac   = RemBits'(ac_s1);
		ad   = RemBits'(ad_s1);
		bb   = RemBits'(bb_s1);
		bc   = RemBits'(bc_s1);
		bd   = RemBits'(bd_s1);
		cc   = RemBits'(cc_s1);
		cd   = RemBits'(cd_s1);
		dd   = RemBits'(dd_s1);
		nsum = aa + bb + cc + dd;
	end

	// stage 2: forms in row-major order and the norm
	always_ff @(posedge clk) begin
		if (en) begin
			form_s2[0] <= aa + bb - cc - dd;
			form_s2[1] <= (bc - ad) <<< 1;
			form_s2[2] <= (ac + bd) <<< 1;
			form_s2[3] <= (ad + bc) <<< 1;
			form_s2[4] <= aa - bb + cc - dd;
			form_s2[5] <= (cd - ab) <<< 1;
			form_s2[6] <= (bd - ac) <<< 1;
			form_s2[7] <= (ab + cd) <<< 1;
			form_s2[8] <= aa - bb - cc + dd;
			norm_s2    <= nsum[MagBits-1:0];
		end
	end

	// stage 3: sign and magnitude, limit compare
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NumEnt; i++) begin
				job_s3.neg[i] <= form_s2[i][RemBits-1];
				job_s3.mag[i] <= form_s2[i][RemBits-1] ? MagBits'(-form_s2[i])
				                                       : form_s2[i][MagBits-1:0];
			end
			job_s3.norm     <= norm_s2;
			job_s3.low_norm <= norm_s2 <= {1'b0, limit_q};
		end
	end

endmodule
`default_nettype wire

FILE: src/q2r_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2r_queue
// two-entry job queue between front and back
// ----------------------------------------------------------------------------
module q2r_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire q2r_pkg::job_t push_job,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output q2r_pkg::job_t     pop_job
);
	import q2r_pkg::*;

	job_t       mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign pop_job = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) full |-> !push)
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) empty |-> !pop)
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");

endmodule
`default_nettype wire

FILE: src/q2r_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// q2r_back
// nine-lane pipelined restoring divider, rounding and output register
// ----------------------------------------------------------------------------
module q2r_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_empty,
	output logic              pop,
	input  wire q2r_pkg::job_t pop_job,
	output logic              out_valid,
	input  wire logic         out_stall,
	output q2r_pkg::mat_t     out_data
);
	import q2r_pkg::*;

	typedef struct packed {
		logic [NumEnt-1:0][RemBits-1:0] rem;
		logic [NumEnt-1:0][QuoBits-1:0] quo;
		logic [NumEnt-1:0]              neg;
		logic [MagBits-1:0]             norm;
		logic                           low_norm;
	} dstage_t;

	dstage_t stage_q [QuoBits];
	logic    vld_q   [QuoBits];
	dstage_t nxt     [QuoBits];
	logic    en;
	logic    out_valid_q;
	mat_t    out_q;
	logic signed [15:0] ent [NumEnt];

	assign en        = !out_valid_q || !out_stall;
	assign pop       = en && !q_empty;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// first quotient bit straight from the queue head (quotient never tops 2^15)
	always_comb begin
		nxt[0].neg      = pop_job.neg;
		nxt[0].norm     = pop_job.norm;
		nxt[0].low_norm = pop_job.low_norm;
		for (int i = 0; i < NumEnt; i++) begin
			if (pop_job.mag[i] >= pop_job.norm) begin
				nxt[0].rem[i] = RemBits'(pop_job.mag[i] - pop_job.norm);
				nxt[0].quo[i] = QuoBits'(1);
			end else begin
				nxt[0].rem[i] = RemBits'(pop_job.mag[i]);
				nxt[0].quo[i] = '0;
			end
		end
	end

	// one shift, compare and subtract per stage
	for (genvar k = 1; k < QuoBits; k++) begin : g_div
		always_comb begin
			logic [RemBits-1:0] r2;
			nxt[k].neg      = stage_q[k-1].neg;
			nxt[k].norm     = stage_q[k-1].norm;
			nxt[k].low_norm = stage_q[k-1].low_norm;
			for (int i = 0; i < NumEnt; i++) begin
				r2 = {stage_q[k-1].rem[i][RemBits-2:0], 1'b0};
				if (r2 >= {1'b0, stage_q[k-1].norm}) begin
					nxt[k].rem[i] = r2 - {1'b0, stage_q[k-1].norm};
					nxt[k].quo[i] = {stage_q[k-1].quo[i][QuoBits-2:0], 1'b1};
				end else begin
					nxt[k].rem[i] = r2;
					nxt[k].quo[i] = {stage_q[k-1].quo[i][QuoBits-2:0], 1'b0};
				end
			end
		end
	end

	for (genvar k = 0; k < QuoBits; k++) begin : g_reg
		always_ff @(posedge clk) begin
			if (en) stage_q[k] <= nxt[k];
		end
		if (k == 0) begin : g_head
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (en) begin
					vld_q[k] <= !q_empty;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_q[k] <= 1'b0;
				end else if (en) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// quotient carries one extra fraction bit: halve with round up, clamp, sign; zero on low norm
	always_comb begin
		logic [QuoBits:0]   rnd;
		logic [QuoBits-1:0] mag;
		for (int i = 0; i < NumEnt; i++) begin
			rnd = ({1'b0, stage_q[QuoBits-1].quo[i]} + (QuoBits+1)'(1)) >> 1;
			mag = (rnd > (QuoBits+1)'(1 << FracBits)) ? QuoBits'(1 << FracBits)
			                                           : rnd[QuoBits-1:0];
			if (stage_q[QuoBits-1].low_norm) ent[i] = '0;
			else if (stage_q[QuoBits-1].neg[i]) ent[i] = -$signed(mag);
			else ent[i] = $signed(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_q[QuoBits-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_q.m00       <= ent[0];
			out_q.m01       <= ent[1];
			out_q.m02       <= ent[2];
			out_q.m10       <= ent[3];
			out_q.m11       <= ent[4];
			out_q.m12       <= ent[5];
			out_q.m20       <= ent[6];
			out_q.m21       <= ent[7];
			out_q.m22       <= ent[8];
			out_q.too_small <= stage_q[QuoBits-1].low_norm;
		end
	end

endmodule
`default_nettype wire
